// ----- hdl/pvsa_pkg.sv -----
// Package for the priority voice slot allocator.
// Holds command and status codes, the slot entry layout and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps

package pvsa_pkg;

   localparam int SLOTS_DEF = 8;

   localparam int CMD_W    = 2;
   localparam int RES_W    = 32;
   localparam int PRIO_W   = 8;
   localparam int HSLOT_W  = 3;
   localparam int GEN_W    = 16;
   localparam int STATUS_W = 3;

   localparam logic [PRIO_W-1:0] PRIO_MAX = '1;

   localparam logic [CMD_W-1:0] CMD_PLAY    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_STOP    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_TAKEN    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_STOLEN   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_STOPPED  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FADING   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_STALE    = 3'd5;
   localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd6;

   typedef struct packed {
      logic [RES_W-1:0]  resource;
      logic [PRIO_W-1:0] priority_lvl;
      logic [GEN_W-1:0]  generation;
      logic              fading;
   } slot_entry_type;

endpackage

// ----- hdl/priority_voice_slot_allocator.sv -----
// Priority voice slot allocator: slot table in a synchronous RAM plus scan sequencer.
// Depends on pvsa_pkg.
`timescale 1ns / 1ps

// Keeps SLOTS voice slots in a one-read-port RAM with a per-slot busy bit (a cleared
// slot reads as all zero, so reset and clears need no sweep). One command at a time:
// a play request reads one slot per cycle from slot 0 until the first free slot or
// the end; stop and release read their one slot; a command that needs no read (zero
// resource, unused code, slot out of range) goes straight to its result. req_ready
// returns in the cycle after the result beat is loaded. The table is written back in
// the cycle the result beat is loaded, before the next command reads it. A finished
// result may wait in the output register while the next command is taken; that
// command's result then holds the sequencer until the waiting beat leaves.
module priority_voice_slot_allocator
   import pvsa_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [RES_W-1:0]    req_resource,
   input  logic [PRIO_W-1:0]   req_priority_req,
   input  logic [HSLOT_W-1:0]  req_slot,
   input  logic [GEN_W-1:0]    req_generation,
   input  logic                req_fade_immediate,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_granted,
   output logic [HSLOT_W-1:0]  rsp_handle_slot,
   output logic [RES_W-1:0]    rsp_handle_resource,
   output logic [GEN_W-1:0]    rsp_handle_generation
);

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_CHECK  = 4'b0100,
      S_RESULT = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // slot table
   slot_entry_type mem [SLOTS];
   logic [SLOTS-1:0] busy_ff;
   slot_entry_type   rd_data_ff;
   logic             rd_busy_ff;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic             wr_en;

   // captured command
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [RES_W-1:0]  res_ff, res_in;
   logic [PRIO_W-1:0] prio_ff, prio_in;
   logic [GEN_W-1:0]  gen_ff, gen_in;
   logic              imm_ff, imm_in;

   // scan bookkeeping
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              rdv_ff, rdv_in;
   logic [AW-1:0]     rd_idx_ff, rd_idx_in;
   logic [PRIO_W-1:0] low_prio_ff, low_prio_in;
   logic [AW-1:0]     low_idx_ff, low_idx_in;
   logic [GEN_W-1:0]  low_gen_ff, low_gen_in;

   // staged result and write-back
   logic [STATUS_W-1:0] st_status_ff, st_status_in;
   logic                st_granted_ff, st_granted_in;
   logic [HSLOT_W-1:0]  st_hslot_ff, st_hslot_in;
   logic [RES_W-1:0]    st_hres_ff, st_hres_in;
   logic [GEN_W-1:0]    st_hgen_ff, st_hgen_in;
   logic                wr_pend_ff, wr_pend_in;
   logic [AW-1:0]       wr_addr_ff, wr_addr_in;
   logic                wr_busy_ff, wr_busy_in;
   slot_entry_type      wr_data_ff, wr_data_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_granted_ff;
   logic [HSLOT_W-1:0]  rsp_hslot_ff;
   logic [RES_W-1:0]    rsp_hres_ff;
   logic [GEN_W-1:0]    rsp_hgen_ff;
   logic                rsp_load;

   slot_entry_type entry;
   logic           slot_in_range;
   logic           req_accept;
   logic [GEN_W-1:0] next_gen;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign slot_in_range = (32'(req_slot) < SLOTS);

   // a slot without its busy bit reads as a cleared slot
   assign entry = rd_busy_ff ? rd_data_ff : '0;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      res_in        = res_ff;
      prio_in       = prio_ff;
      gen_in        = gen_ff;
      imm_in        = imm_ff;
      cnt_in        = cnt_ff;
      rdv_in        = 1'b0;
      rd_idx_in     = rd_idx_ff;
      low_prio_in   = low_prio_ff;
      low_idx_in    = low_idx_ff;
      low_gen_in    = low_gen_ff;
      st_status_in  = st_status_ff;
      st_granted_in = st_granted_ff;
      st_hslot_in   = st_hslot_ff;
      st_hres_in    = st_hres_ff;
      st_hgen_in    = st_hgen_ff;
      wr_pend_in    = wr_pend_ff;
      wr_addr_in    = wr_addr_ff;
      wr_busy_in    = wr_busy_ff;
      wr_data_in    = wr_data_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      rsp_load      = 1'b0;
      next_gen      = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               cmd_in        = req_cmd;
               res_in        = req_resource;
               prio_in       = req_priority_req;
               gen_in        = req_generation;
               imm_in        = req_fade_immediate;
               st_status_in  = ST_IGNORED;
               st_granted_in = 1'b0;
               st_hslot_in   = '0;
               st_hres_in    = '0;
               st_hgen_in    = '0;
               wr_pend_in    = 1'b0;
               state_in      = S_RESULT;
               case (req_cmd)
                  CMD_PLAY: begin
                     if (req_resource != '0) begin
                        cnt_in      = '0;
                        low_prio_in = PRIO_MAX;
                        low_idx_in  = '0;
                        low_gen_in  = '0;
                        state_in    = S_SCAN;
                     end
                  end
                  CMD_STOP: begin
                     if (req_resource != '0) begin
                        if (!slot_in_range) begin
                           st_status_in = ST_STALE;
                        end else begin
                           rd_en    = 1'b1;
                           rd_addr  = AW'(req_slot);
                           state_in = S_CHECK;
                        end
                     end
                  end
                  CMD_RELEASE: begin
                     if (slot_in_range) begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(req_slot);
                        state_in = S_CHECK;
                     end
                  end
                  default: ;
               endcase
               wr_addr_in = AW'(req_slot);
            end
         end

         S_SCAN: begin
            // issue slot cnt while evaluating the slot read last cycle
            if (cnt_ff < CW'(SLOTS)) begin
               rd_en     = 1'b1;
               rd_addr   = AW'(cnt_ff);
               rd_idx_in = AW'(cnt_ff);
               cnt_in    = cnt_ff + 1'b1;
               rdv_in    = 1'b1;
            end
            if (rdv_ff) begin
               // ties go to the later slot
               if (entry.priority_lvl <= low_prio_ff) begin
                  low_prio_in = entry.priority_lvl;
                  low_idx_in  = rd_idx_ff;
                  low_gen_in  = entry.generation;
               end
               if (entry.resource == '0) begin
                  next_gen      = entry.generation + 1'b1;
                  st_status_in  = ST_TAKEN;
                  st_granted_in = 1'b1;
                  st_hslot_in   = HSLOT_W'(rd_idx_ff);
                  st_hres_in    = res_ff;
                  st_hgen_in    = next_gen;
                  wr_pend_in    = 1'b1;
                  wr_addr_in    = rd_idx_ff;
                  wr_busy_in    = 1'b1;
                  wr_data_in    = '{resource: res_ff, priority_lvl: prio_ff,
                                    generation: next_gen, fading: 1'b0};
                  state_in      = S_RESULT;
               end else if (rd_idx_ff == AW'(SLOTS - 1)) begin
                  if (low_prio_in < prio_ff) begin
                     next_gen      = low_gen_in + 1'b1;
                     st_status_in  = ST_STOLEN;
                     st_granted_in = 1'b1;
                     st_hslot_in   = HSLOT_W'(low_idx_in);
                     st_hres_in    = res_ff;
                     st_hgen_in    = next_gen;
                     wr_pend_in    = 1'b1;
                     wr_addr_in    = low_idx_in;
                     wr_busy_in    = 1'b1;
                     wr_data_in    = '{resource: res_ff, priority_lvl: prio_ff,
                                       generation: next_gen, fading: 1'b0};
                  end else begin
                     st_status_in = ST_REJECTED;
                  end
                  state_in = S_RESULT;
               end
            end
         end

         S_CHECK: begin
            wr_busy_in = 1'b0;
            wr_data_in = entry;
            if (cmd_ff == CMD_STOP) begin
               if (entry.resource != res_ff || entry.generation != gen_ff) begin
                  st_status_in = ST_STALE;
               end else if (imm_ff) begin
                  st_status_in = ST_STOPPED;
                  wr_pend_in   = 1'b1;
               end else begin
                  st_status_in      = ST_FADING;
                  wr_pend_in        = 1'b1;
                  wr_busy_in        = 1'b1;
                  wr_data_in.fading = 1'b1;
               end
            end else begin
               if (entry.resource == '0) begin
                  st_status_in = ST_IGNORED;
               end else begin
                  st_status_in = ST_STOPPED;
                  wr_pend_in   = 1'b1;
               end
            end
            state_in = S_RESULT;
         end

         S_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               wr_en    = wr_pend_ff;
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rdv_ff       <= 1'b0;
         wr_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rdv_ff       <= rdv_in;
         wr_pend_ff   <= wr_pend_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      res_ff        <= res_in;
      prio_ff       <= prio_in;
      gen_ff        <= gen_in;
      imm_ff        <= imm_in;
      cnt_ff        <= cnt_in;
      rd_idx_ff     <= rd_idx_in;
      low_prio_ff   <= low_prio_in;
      low_idx_ff    <= low_idx_in;
      low_gen_ff    <= low_gen_in;
      st_status_ff  <= st_status_in;
      st_granted_ff <= st_granted_in;
      st_hslot_ff   <= st_hslot_in;
      st_hres_ff    <= st_hres_in;
      st_hgen_ff    <= st_hgen_in;
      wr_addr_ff    <= wr_addr_in;
      wr_busy_ff    <= wr_busy_in;
      wr_data_ff    <= wr_data_in;
      if (rsp_load) begin
         rsp_status_ff  <= st_status_ff;
         rsp_granted_ff <= st_granted_ff;
         rsp_hslot_ff   <= st_hslot_ff;
         rsp_hres_ff    <= st_hres_ff;
         rsp_hgen_ff    <= st_hgen_ff;
      end
   end

   // slot RAM, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr_ff] <= wr_data_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // busy bits: clearing a slot only drops its bit
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= '0;
         rd_busy_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            busy_ff[wr_addr_ff] <= wr_busy_ff;
         end
         if (rd_en) begin
            rd_busy_ff <= busy_ff[rd_addr];
         end
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_granted           = rsp_granted_ff;
   assign rsp_handle_slot       = rsp_hslot_ff;
   assign rsp_handle_resource   = rsp_hres_ff;
   assign rsp_handle_generation = rsp_hgen_ff;

endmodule

// ----- verif/tb.sv -----
// Testbench for priority_voice_slot_allocator: directed and random play/stop/release traffic.
// Results are checked against an in-bench slot table predictor. Depends on pvsa_pkg.
`timescale 1ns / 1ps

module tb
   import pvsa_pkg::*;
();

   localparam int NSLOT = SLOTS_DEF;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 2 * NSLOT + 8;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                granted;
      logic [HSLOT_W-1:0]  hslot;
      logic [RES_W-1:0]    hres;
      logic [GEN_W-1:0]    hgen;
   } voice_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [CMD_W-1:0]    req_cmd = '0;
   logic [RES_W-1:0]    req_resource = '0;
   logic [PRIO_W-1:0]   req_priority_req = '0;
   logic [HSLOT_W-1:0]  req_slot = '0;
   logic [GEN_W-1:0]    req_generation = '0;
   logic                req_fade_immediate = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_granted;
   logic [HSLOT_W-1:0]  rsp_handle_slot;
   logic [RES_W-1:0]    rsp_handle_resource;
   logic [GEN_W-1:0]    rsp_handle_generation;

   // predicted slot table
   logic [RES_W-1:0]  res_tbl  [NSLOT];
   logic [PRIO_W-1:0] prio_tbl [NSLOT];
   logic [GEN_W-1:0]  gen_tbl  [NSLOT];
   logic              fade_tbl [NSLOT];

   voice_result_type pending_results[$];
   int            errors = 0;
   int            status_seen [8];
   int            beats_sent = 0;
   int            idle_cycles = 0;
   logic          no_gaps = 1'b0;

   always #2 clock = ~clock;

   priority_voice_slot_allocator dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_cmd               (req_cmd),
      .req_resource          (req_resource),
      .req_priority_req      (req_priority_req),
      .req_slot              (req_slot),
      .req_generation        (req_generation),
      .req_fade_immediate    (req_fade_immediate),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_granted           (rsp_granted),
      .rsp_handle_slot       (rsp_handle_slot),
      .rsp_handle_resource   (rsp_handle_resource),
      .rsp_handle_generation (rsp_handle_generation)
   );

   function automatic void clear_voice(input int s);
      res_tbl[s]  = '0;
      prio_tbl[s] = '0;
      gen_tbl[s]  = '0;
      fade_tbl[s] = 1'b0;
   endfunction

   // Applies one command to the predicted table and returns the expected result.
   function automatic voice_result_type allocate_voice(
      input logic [CMD_W-1:0]   cmd,
      input logic [RES_W-1:0]   res,
      input logic [PRIO_W-1:0]  prio,
      input logic [HSLOT_W-1:0] sl,
      input logic [GEN_W-1:0]   gen,
      input logic               imm
   );
      voice_result_type  r;
      logic [PRIO_W-1:0] low_prio;
      int                low_idx;
      int                pick;
      logic              found;
      r = '0;
      r.status = ST_IGNORED;
      case (cmd)
         CMD_PLAY: begin
            if (res != '0) begin
               low_prio = PRIO_MAX;
               low_idx  = 0;
               pick     = 0;
               found    = 1'b0;
               // scan stops at first free slot; ties on priority go to the later slot
               for (int d = 0; d < NSLOT; d++) begin
                  if (!found) begin
                     if (prio_tbl[d] <= low_prio) begin
                        low_prio = prio_tbl[d];
                        low_idx  = d;
                     end
                     if (res_tbl[d] == '0) begin
                        found = 1'b1;
                        pick  = d;
                     end
                  end
               end
               if (found) begin
                  r.status = ST_TAKEN;
               end else if (low_prio < prio) begin
                  r.status = ST_STOLEN;
                  pick = low_idx;
               end else begin
                  r.status = ST_REJECTED;
               end
               if (r.status != ST_REJECTED) begin
                  gen_tbl[pick]  = gen_tbl[pick] + 1'b1;
                  res_tbl[pick]  = res;
                  prio_tbl[pick] = prio;
                  fade_tbl[pick] = 1'b0;
                  r.granted = 1'b1;
                  r.hslot   = HSLOT_W'(pick);
                  r.hres    = res;
                  r.hgen    = gen_tbl[pick];
               end
            end
         end
         CMD_STOP: begin
            if (res != '0) begin
               if (int'(sl) >= NSLOT || res_tbl[sl] != res || gen_tbl[sl] != gen) begin
                  r.status = ST_STALE;
               end else if (imm) begin
                  clear_voice(int'(sl));
                  r.status = ST_STOPPED;
               end else begin
                  fade_tbl[sl] = 1'b1;
                  r.status = ST_FADING;
               end
            end
         end
         CMD_RELEASE: begin
            if (int'(sl) < NSLOT && res_tbl[sl] != '0) begin
               clear_voice(int'(sl));
               r.status = ST_STOPPED;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // Drives one request beat, waits for its acceptance, and queues the predicted result.
   // Valid is left high on return; the next call keeps it or lowers it for a gap, and the caller lowers it at the end.
   task automatic send_voice_cmd(
      input  logic [CMD_W-1:0]    cmd,
      input  logic [RES_W-1:0]    res,
      input  logic [PRIO_W-1:0]   prio,
      input  logic [HSLOT_W-1:0]  sl,
      input  logic [GEN_W-1:0]    gen,
      input  logic                imm,
      output logic [STATUS_W-1:0] st
   );
      int               gap;
      voice_result_type want;
      gap = no_gaps ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_cmd            <= cmd;
      req_resource       <= res;
      req_priority_req   <= prio;
      req_slot           <= sl;
      req_generation     <= gen;
      req_fade_immediate <= imm;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      want = allocate_voice(cmd, res, prio, sl, gen, imm);
      pending_results.push_back(want);
      status_seen[want.status]++;
      beats_sent++;
      st = want.status;
   endtask

   task automatic check_field(input string name, input logic [RES_W-1:0] want,
                              input logic [RES_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   // Play with a zero resource, fill every slot, then reject and steal with ties on the lowest priority.
   task automatic test_play_fill_and_steal();
      logic [PRIO_W-1:0]   fill_prio [NSLOT] = '{8'd255, 8'd5, 8'd5, 8'd128,
                                                 8'd64, 8'd200, 8'd77, 8'd9};
      logic [STATUS_W-1:0] st;
      send_voice_cmd(CMD_PLAY, '0, 8'd100, '0, '0, 1'b0, st);
      send_voice_cmd(CMD_PLAY, 32'hFFFF_FFFF, fill_prio[0], '0, '0, 1'b0, st);
      for (int i = 1; i < NSLOT; i++)
         send_voice_cmd(CMD_PLAY, RES_W'(i), fill_prio[i], '1, '1, 1'b1, st);
      send_voice_cmd(CMD_PLAY, 32'h1234_5678, 8'd5, '0, '0, 1'b0, st);
      send_voice_cmd(CMD_PLAY, 32'h8000_0001, 8'd6, '0, '0, 1'b0, st);
      send_voice_cmd(CMD_PLAY, 32'hFFFF_FFFF, 8'd0, '0, '0, 1'b0, st);
   endtask

   task automatic test_stop_and_release();
      logic [STATUS_W-1:0] st;
      send_voice_cmd(CMD_STOP, '0, '0, 3'd7, gen_tbl[7], 1'b1, st);
      send_voice_cmd(CMD_STOP, res_tbl[7], '0, 3'd7, gen_tbl[7] + 1'b1, 1'b0, st);
      send_voice_cmd(CMD_STOP, res_tbl[7] + 1'b1, '0, 3'd7, gen_tbl[7], 1'b0, st);
      send_voice_cmd(CMD_STOP, res_tbl[7], '1, 3'd7, 16'hFFFF, 1'b1, st);
      // fading twice stays fading, then an immediate stop clears it
      send_voice_cmd(CMD_STOP, res_tbl[7], '0, 3'd7, gen_tbl[7], 1'b0, st);
      send_voice_cmd(CMD_STOP, res_tbl[7], '0, 3'd7, gen_tbl[7], 1'b0, st);
      send_voice_cmd(CMD_STOP, res_tbl[7], '0, 3'd7, gen_tbl[7], 1'b1, st);
      send_voice_cmd(CMD_RELEASE, '0, '0, 3'd7, '0, 1'b0, st);
      send_voice_cmd(CMD_RELEASE, '1, '1, 3'd3, '1, 1'b1, st);
      send_voice_cmd(CMD_UNUSED, '1, '1, '1, '1, 1'b1, st);
      send_voice_cmd(CMD_PLAY, 32'h5A5A_A5A5, 8'd1, '0, '0, 1'b0, st);
   endtask

   // Mostly coherent traffic: plays, valid-handle stops and releases of random slots,
   // mixed with stale handles, zero resources and unused commands.
   task automatic test_random_traffic(input int target);
      int                  counted;
      int                  pick;
      int                  s;
      logic [CMD_W-1:0]    cmd;
      logic [RES_W-1:0]    res;
      logic [PRIO_W-1:0]   prio;
      logic [GEN_W-1:0]    gen;
      logic [STATUS_W-1:0] st;
      counted = 0;
      while (counted < target) begin
         no_gaps = ((counted / 100) % 3 == 2);
         pick = $urandom_range(0, 99);
         s    = $urandom_range(0, NSLOT - 1);
         res  = $urandom();
         gen  = GEN_W'($urandom());
         prio = PRIO_W'($urandom_range(0, 255));
         if (pick < 45) begin
            cmd = CMD_PLAY;
            if (pick < 20) res = $urandom_range(1, 16);
            else if (pick < 22) res = '0;
         end else if (pick < 75) begin
            cmd = CMD_STOP;
            if (res_tbl[s] != '0 && $urandom_range(0, 3) != 0) begin
               res = res_tbl[s];
               gen = gen_tbl[s];
               if ($urandom_range(0, 7) == 0) begin
                  if ($urandom_range(0, 1) != 0) gen[$urandom_range(0, GEN_W - 1)] ^= 1'b1;
                  else res[$urandom_range(0, RES_W - 1)] ^= 1'b1;
               end
            end
         end else if (pick < 95) begin
            cmd = CMD_RELEASE;
         end else begin
            cmd = CMD_W'($urandom_range(0, 3));
         end
         send_voice_cmd(cmd, res, prio, HSLOT_W'(s), gen, 1'($urandom_range(0, 1)), st);
         counted++;
      end
      no_gaps = 1'b0;
   endtask

   // result side: each beat draws its own stall, none while no_gaps is set
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, 3);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      voice_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result beat, status %0d", $time, rsp_status);
            errors++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", RES_W'(want.status), RES_W'(rsp_status));
            check_field("granted", RES_W'(want.granted), RES_W'(rsp_granted));
            check_field("handle_slot", RES_W'(want.hslot), RES_W'(rsp_handle_slot));
            check_field("handle_resource", want.hres, rsp_handle_resource);
            check_field("handle_generation", RES_W'(want.hgen),
                        RES_W'(rsp_handle_generation));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < NSLOT; i++) clear_voice(i);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_play_fill_and_steal();
      test_stop_and_release();
      test_random_traffic(1330);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d commands: %0d taken, %0d stolen, %0d rejected.", beats_sent,
               status_seen[ST_TAKEN], status_seen[ST_STOLEN], status_seen[ST_REJECTED]);
      $display("Stops/releases: %0d stopped, %0d fading, %0d stale, %0d ignored.",
               status_seen[ST_STOPPED], status_seen[ST_FADING], status_seen[ST_STALE],
               status_seen[ST_IGNORED]);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
